// ===== design/rdbem_pkg.sv =====
`default_nettype none
package rdbem_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int LANES       = 4;
    localparam int NUM_STORES  = 3;
    localparam int ROW_BITS    = OFFSET_BITS - 2;
    localparam int BANK_DEPTH  = 1 << ROW_BITS;

    localparam int ADDR_W  = 32;
    localparam int TAG_LSB = 20;
    localparam int TAG_W   = ADDR_W - TAG_LSB;
    localparam int OFS_W   = TAG_LSB;

    typedef logic [ROW_BITS-1:0] row_t;
    typedef logic [OFS_W:0]      span_t;
    typedef logic [TAG_W-1:0]    tag_t;
    typedef logic [1:0]          store_sel_t;

    localparam span_t STORE_DEPTH = span_t'(1 << OFFSET_BITS);

    localparam tag_t TAG_PROGRAM = 12'h004;
    localparam tag_t TAG_DATA    = 12'h100;
    localparam tag_t TAG_STACK   = 12'h7FF;

    localparam store_sel_t STORE_PROGRAM = 2'd0;
    localparam store_sel_t STORE_DATA    = 2'd1;
    localparam store_sel_t STORE_STACK   = 2'd2;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_TAG      = 2'd1;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

    typedef struct packed {
        logic       we;
        logic       re;
        row_t       row;
        logic [7:0] wdata;
    } bank_ctl_t;

    function automatic logic [2:0] access_bytes(input logic [1:0] size_code);
        logic [2:0] n;
        case (size_code)
            SIZE_BYTE: n = 3'd1;
            SIZE_HALF: n = 3'd2;
            SIZE_WORD: n = 3'd4;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== design/rdbem_req_if.sv =====
`default_nettype none
interface rdbem_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] address;
    logic [1:0]  size_code;
    logic [31:0] write_data;

    modport source (output valid, cmd, address, size_code, write_data, input ready);
    modport sink   (input valid, cmd, address, size_code, write_data, output ready);
endinterface
`default_nettype wire

// ===== design/rdbem_rsp_if.sv =====
`default_nettype none
interface rdbem_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [1:0]  status;

    modport source (output valid, read_data, status, input ready);
    modport sink   (input valid, read_data, status, output ready);
endinterface
`default_nettype wire

// ===== design/rdbem_bank.sv =====
`default_nettype none
// One byte lane of one store: single port, registered read that holds when idle.
module rdbem_bank
    import rdbem_pkg::*;
(
    input  wire logic       clk,
    input  wire bank_ctl_t  ctl,
    output logic [7:0]      rdata
);

    logic [7:0] mem [BANK_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.row] <= ctl.wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[ctl.row];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/region_decoded_big_endian_memory_unit.sv =====
`default_nettype none
// channel  dir  fields                                   word accepted when
// req      in   cmd, address, size_code, write_data      req.valid && req.ready
// rsp      out  read_data, status                        rsp.valid && rsp.ready
//
// One word per cycle sustained while rsp is not stalled; a result passes through the
// bank read register, then the output register, after its request is taken.
// Each store is four byte-lane banks, so any aligned or unaligned access needs
// one access per lane bank; a write lands at the accept edge, a following read sees it.
// After reset a clearing pass zeroes one row of every bank per cycle, through
// all 2^(OFFSET_BITS-2) rows (16384), with req.ready low.
// A stall on rsp holds the output word and the bank read registers.
module region_decoded_big_endian_memory_unit
    import rdbem_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rdbem_req_if.sink    req,
    rdbem_rsp_if.source  rsp
);

    bank_ctl_t   bank_ctl   [NUM_STORES][LANES];
    logic [7:0]  bank_rdata [NUM_STORES][LANES];

    logic        clearing_reg;
    row_t        clr_row_reg;

    logic        s1_valid_reg;
    logic        s1_read_reg;
    store_sel_t  s1_store_reg;
    logic [1:0]  s1_lane0_reg;
    logic [2:0]  s1_bytes_reg;
    logic [1:0]  s1_status_reg;

    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [1:0]  out_status_reg;

    tag_t        tag;
    logic [OFS_W-1:0] ofs;
    logic        hit;
    store_sel_t  sel;
    logic [2:0]  nbytes;
    span_t       span_end;
    logic [1:0]  status0;
    logic        go;
    logic [1:0]  lane0;
    row_t        row0;
    row_t        row1;
    logic        in_fire;
    logic        s1_adv;
    logic [NUM_STORES-1:0] store_en;

    logic [7:0]  lane_byte [LANES];
    logic [31:0] assembled;

    genvar gs, gl;

    assign tag      = req.address[ADDR_W-1:TAG_LSB];
    assign ofs      = req.address[OFS_W-1:0];
    assign nbytes   = access_bytes(req.size_code);
    assign span_end = {1'b0, ofs} + span_t'(nbytes);
    assign lane0    = ofs[1:0];
    assign row0     = ofs[OFFSET_BITS-1:2];
    assign row1     = row0 + row_t'(1);

    always_comb
    begin
        hit = 1'b1;
        sel = STORE_PROGRAM;
        case (tag)
            TAG_PROGRAM: sel = STORE_PROGRAM;
            TAG_DATA:    sel = STORE_DATA;
            TAG_STACK:   sel = STORE_STACK;
            default:     hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (!hit)
            status0 = ST_BAD_TAG;
        else if (span_end > STORE_DEPTH)
            status0 = ST_OUT_OF_RANGE;
        else
            status0 = ST_OK;
    end

    assign go        = (status0 == ST_OK);
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign in_fire   = req.valid && req.ready;

    // Lane L holds byte k = (L - lane0) mod 4 of the access; lanes below lane0 wrap
    // into the next row.
    always_comb
    begin
        for (int s = 0; s < NUM_STORES; s++)
        begin
            store_en[s] = in_fire && go && (sel == store_sel_t'(s));
            for (int l = 0; l < LANES; l++)
            begin
                logic [1:0] k;
                logic [1:0] widx;
                logic       active;
                k      = 2'(l) - lane0;
                active = ({1'b0, k} < nbytes);
                widx   = 2'(nbytes - 3'd1 - {1'b0, k});
                if (clearing_reg)
                begin
                    bank_ctl[s][l].we    = 1'b1;
                    bank_ctl[s][l].re    = 1'b0;
                    bank_ctl[s][l].row   = clr_row_reg;
                    bank_ctl[s][l].wdata = '0;
                end
                else
                begin
                    bank_ctl[s][l].we    = store_en[s] && active && (req.cmd == CMD_WRITE);
                    bank_ctl[s][l].re    = store_en[s] && active && (req.cmd == CMD_READ);
                    bank_ctl[s][l].row   = (2'(l) < lane0) ? row1 : row0;
                    bank_ctl[s][l].wdata = req.write_data[8*widx +: 8];
                end
            end
        end
    end

    generate
        for (gs = 0; gs < NUM_STORES; gs++)
        begin : g_store
            for (gl = 0; gl < LANES; gl++)
            begin : g_lane
                rdbem_bank u_bank (
                    .clk   (clk),
                    .ctl   (bank_ctl[gs][gl]),
                    .rdata (bank_rdata[gs][gl])
                );
            end
        end
    endgenerate

    always_comb
    begin
        case (s1_store_reg)
            STORE_DATA:  lane_byte = bank_rdata[STORE_DATA];
            STORE_STACK: lane_byte = bank_rdata[STORE_STACK];
            default:     lane_byte = bank_rdata[STORE_PROGRAM];
        endcase
    end

    // Big-endian: byte k of the access goes in first, ends up most significant.
    always_comb
    begin
        assembled = '0;
        if (s1_read_reg)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                if (3'(k) < s1_bytes_reg)
                begin
                    assembled = {assembled[23:0], lane_byte[2'(k) + s1_lane0_reg]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clr_row_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_row_reg <= clr_row_reg + row_t'(1);
                if (clr_row_reg == row_t'(BANK_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_read_reg   <= go && (req.cmd == CMD_READ);
            s1_store_reg  <= sel;
            s1_lane0_reg  <= lane0;
            s1_bytes_reg  <= nbytes;
            s1_status_reg <= status0;
        end
        if (s1_adv)
        begin
            out_data_reg   <= assembled;
            out_status_reg <= s1_status_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.status    = out_status_reg;

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !req.ready
    ) else $error("request taken during clearing pass");

    a_one_store_per_access: assert property (
        @(posedge clk) disable iff (!rst_n)
        $onehot0(store_en)
    ) else $error("more than one store enabled");

    a_clear_ends: assert property (
        @(posedge clk) disable iff (!rst_n)
        (clearing_reg && clr_row_reg == row_t'(BANK_DEPTH - 1)) |=> !clearing_reg
    ) else $error("clearing pass did not end after last row");

    a_error_reads_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_status_reg != ST_OK) |=> (rsp.read_data == '0)
    ) else $error("nonzero read data on error status");

    a_s1_not_lost: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg
    ) else $error("pending access dropped");

endmodule
`default_nettype wire
